// ----- sv/rhp_pkg.sv -----
package rhp_pkg;

   // result kinds
   localparam logic [2:0] KIND_FIXED    = 3'd0;
   localparam logic [2:0] KIND_CSRC     = 3'd1;
   localparam logic [2:0] KIND_EXT_HEAD = 3'd2;
   localparam logic [2:0] KIND_EXT_WORD = 3'd3;
   localparam logic [2:0] KIND_REJECT   = 3'd4;

   localparam logic [15:0] MIN_HEADER_BYTES   = 16'd11;
   localparam logic [15:0] FIXED_HEADER_BYTES = 16'd8;
   localparam logic [7:0]  CSRC_MASK          = 8'h0f;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [1:0]  version;
      logic        padding;
      logic        has_extension;
      logic [3:0]  csrc_count;
      logic        marker;
      logic [6:0]  payload_type;
      logic [15:0] sequence_number;
      logic [31:0] word_value;
      logic [15:0] ext_length;
      logic [15:0] ext_type;
      logic        last;
   } result_type;

   typedef struct packed {
      logic full;
      logic pop;
   } buf_status_type;

endpackage

// ----- sv/rhp_parse.sv -----
module rhp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   input  logic               first_byte,
   input  logic [15:0]        packet_length,
   output logic               res_valid,
   output rhp_pkg::result_type res
);
   import rhp_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_HEAD = 3'd1;
   localparam logic [2:0] PH_SSRC = 3'd2;
   localparam logic [2:0] PH_CSRC = 3'd3;
   localparam logic [2:0] PH_EXTH = 3'd4;
   localparam logic [2:0] PH_EXTW = 3'd5;
   localparam logic [2:0] PH_DONE = 3'd6;

   logic [2:0]  phase_ff,  phase_in;
   logic [1:0]  count_ff,  count_in;
   logic [15:0] words_ff,  words_in;
   logic [7:0]  flags_ff,  flags_in;
   logic [7:0]  mtype_ff,  mtype_in;
   logic [15:0] seq_ff,    seq_in;
   logic [31:0] asm_ff,    asm_in;

   logic [31:0] asm_shift;
   logic [15:0] min_len;
   logic        ext_flag;
   logic [3:0]  cc;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      words_in  = words_ff;
      flags_in  = flags_ff;
      mtype_in  = mtype_ff;
      seq_in    = seq_ff;
      asm_in    = asm_ff;
      res_valid = 1'b0;
      res       = '0;
      asm_shift = {asm_ff[23:0], data_byte};
      ext_flag  = flags_ff[4];
      cc        = flags_ff[3:0];
      // 8 + 4 * csrc count, csrc count in the low nibble of the start byte
      min_len   = FIXED_HEADER_BYTES + {10'd0, data_byte[3:0], 2'b00};

      if (first_byte) begin
         flags_in = data_byte;
         count_in = 2'd1;
         words_in = '0;
         asm_in   = '0;
         if (packet_length < MIN_HEADER_BYTES || packet_length < min_len) begin
            phase_in        = PH_DONE;
            res_valid       = 1'b1;
            res.result_kind = KIND_REJECT;
            res.last        = 1'b1;
         end else begin
            phase_in = PH_HEAD;
         end
      end else begin
         unique case (phase_ff)
            PH_HEAD: begin
               unique case (count_ff)
                  2'd1: begin
                     mtype_in = data_byte;
                     count_in = 2'd2;
                  end
                  2'd2: begin
                     seq_in   = {data_byte, 8'h00};
                     count_in = 2'd3;
                  end
                  default: begin
                     seq_in   = seq_ff | {8'h00, data_byte};
                     phase_in = PH_SSRC;
                     count_in = 2'd0;
                  end
               endcase
            end
            PH_SSRC, PH_CSRC, PH_EXTH, PH_EXTW: begin
               asm_in   = asm_shift;
               count_in = count_ff + 2'd1;
               if (count_ff == 2'd3) begin
                  res_valid = 1'b1;
                  unique case (phase_ff)
                     PH_SSRC: begin
                        res.result_kind     = KIND_FIXED;
                        res.version         = flags_ff[7:6];
                        res.padding         = flags_ff[5];
                        res.has_extension   = flags_ff[4];
                        res.csrc_count      = cc;
                        res.marker          = mtype_ff[7];
                        res.payload_type    = mtype_ff[6:0];
                        res.sequence_number = seq_ff;
                        res.word_value      = asm_shift;
                        if (cc != 4'd0) begin
                           words_in = {12'd0, cc};
                           phase_in = PH_CSRC;
                        end else if (ext_flag) begin
                           phase_in = PH_EXTH;
                        end else begin
                           phase_in = PH_DONE;
                           res.last = 1'b1;
                        end
                     end
                     PH_CSRC: begin
                        res.result_kind = KIND_CSRC;
                        res.word_value  = asm_shift;
                        words_in        = words_ff - 16'd1;
                        if (words_ff == 16'd1) begin
                           if (ext_flag) begin
                              phase_in = PH_EXTH;
                           end else begin
                              phase_in = PH_DONE;
                              res.last = 1'b1;
                           end
                        end
                     end
                     PH_EXTH: begin
                        res.result_kind = KIND_EXT_HEAD;
                        res.ext_length  = asm_shift[31:16];
                        res.ext_type    = asm_shift[15:0];
                        words_in        = asm_shift[31:16];
                        if (asm_shift[31:16] == 16'd0) begin
                           phase_in = PH_DONE;
                           res.last = 1'b1;
                        end else begin
                           phase_in = PH_EXTW;
                        end
                     end
                     default: begin
                        res.result_kind = KIND_EXT_WORD;
                        res.word_value  = asm_shift;
                        words_in        = words_ff - 16'd1;
                        if (words_ff == 16'd1) begin
                           phase_in = PH_DONE;
                           res.last = 1'b1;
                        end
                     end
                  endcase
               end
            end
            default: begin
               // idle or finished: stray bytes are dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         words_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         words_ff <= words_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         flags_ff <= flags_in;
         mtype_ff <= mtype_in;
         seq_ff   <= seq_in;
         asm_ff   <= asm_in;
      end
   end

endmodule

// ----- sv/rhp_out_buf.sv -----
module rhp_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rhp_pkg::result_type     push_data,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output rhp_pkg::result_type     rsp_data,
   output rhp_pkg::buf_status_type status
);
   import rhp_pkg::*;

   result_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       pop;

   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_data    = mem[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign status.full = (count_ff == 2'd2);
   assign status.pop  = pop;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/rtp_header_parser.sv -----
// RTP-style header parser, one packet byte per word.
// Request channel (req_*): a byte, a start mark and, on the start byte, the total
// packet length. A word moves when req_valid is high and req_stall is low.
// Response channel (rsp_*): one parsed field group per word - fixed header with
// SSRC, each CSRC word, the extension header, each extension word, or a reject
// for a packet too short for its header. rsp_last flags the packet's final word.
// Payload bytes and stray bytes give no response.
// Path: an accepted byte lands in the input register and is parsed from there
// once the output buffer has room; its response is written into that buffer,
// which drives rsp_* directly.
// Throughput: one byte per cycle, sustained, as long as responses are taken.
// The parser holds only a phase, a byte counter, a word counter and a few
// header bytes, so every byte is parsed in one pass between two registers.
// Stall: responses queue in a two-word output buffer; when it is full and
// rsp_stall is high, a byte held in the input register stays and req_stall rises. The
// response on offer does not change while stalled.
// Reset (synchronous, active high): parser returns to idle waiting for a
// start byte; input register and output buffer are emptied.
module rtp_header_parser (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic [15:0] req_packet_length,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [1:0]  rsp_version,
   output logic        rsp_padding,
   output logic        rsp_has_extension,
   output logic [3:0]  rsp_csrc_count,
   output logic        rsp_marker,
   output logic [6:0]  rsp_payload_type,
   output logic [15:0] rsp_sequence_number,
   output logic [31:0] rsp_word_value,
   output logic [15:0] rsp_ext_length,
   output logic [15:0] rsp_ext_type,
   output logic        rsp_last
);
   import rhp_pkg::*;

   // input register
   logic        in_vld_ff,   in_vld_in;
   logic [7:0]  in_byte_ff;
   logic        in_first_ff;
   logic [15:0] in_len_ff;

   logic           req_take;   // word accepted this edge
   logic           advance;    // input register parsed this edge
   logic           res_valid;
   result_type     res;
   result_type     rsp_data;
   buf_status_type buf_status;

   // parse the held byte whenever the buffer has room, or frees a slot now
   assign advance   = in_vld_ff && (!buf_status.full || buf_status.pop);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
         in_len_ff   <= req_packet_length;
      end
   end

   rhp_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .data_byte     (in_byte_ff),
      .first_byte    (in_first_ff),
      .packet_length (in_len_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // two-word result buffer decouples the response side
   rhp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && res_valid),
      .push_data (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (buf_status)
   );

   assign rsp_result_kind     = rsp_data.result_kind;
   assign rsp_version         = rsp_data.version;
   assign rsp_padding         = rsp_data.padding;
   assign rsp_has_extension   = rsp_data.has_extension;
   assign rsp_csrc_count      = rsp_data.csrc_count;
   assign rsp_marker          = rsp_data.marker;
   assign rsp_payload_type    = rsp_data.payload_type;
   assign rsp_sequence_number = rsp_data.sequence_number;
   assign rsp_word_value      = rsp_data.word_value;
   assign rsp_ext_length      = rsp_data.ext_length;
   assign rsp_ext_type        = rsp_data.ext_type;
   assign rsp_last            = rsp_data.last;

endmodule
